// ===== rtl/core/nte_pkg.sv =====
// Neighbor table engine package: operation and status codes, size defaults,
// and the fixed-point smoothing helper. No dependencies.
`timescale 1ns / 1ps

package nte_pkg;

  localparam int unsigned EntriesDef = 32;
  localparam int unsigned IdBitsDef  = 64;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RssiW  = 8;
  localparam int unsigned SlotW  = 5;
  localparam int unsigned CountW = 6;

  localparam logic [TimeW-1:0] TimeoutRst = 32'd300000;

  // x/5 for |x| < 1024 as (|x| * 205) >> 10
  localparam logic [18:0] Div5Recip = 19'd205;
  localparam int unsigned Div5Shift = 10;

  typedef enum logic [1:0] {
    OP_HEARD = 2'd0,
    OP_PRUNE = 2'd1,
    OP_COUNT = 2'd2,
    OP_GET   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NEW      = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_INACTIVE = 2'd3
  } status_e;

  // Signed divide by five, truncated toward zero; x lies in -640..635.
  function automatic logic [RssiW-1:0] div5_trunc(input logic signed [10:0] x);
    logic [10:0]      mag;
    logic [18:0]      prod;
    logic [RssiW-1:0] quo;
    mag  = x[10] ? 11'(-x) : 11'(x);
    prod = 19'(mag) * Div5Recip;
    quo  = prod[Div5Shift +: RssiW];
    return x[10] ? RssiW'(-quo) : quo;
  endfunction

endpackage

// ===== rtl/core/neighbor_table_engine.sv =====
// Heard and prune scan the store from the accepting edge up to the done strobe:
// one store read per slot through the single compare unit, then an update step.
// Get waits in S_GETW; count answers straight from idle. Elsewhere busy_o drops as
// done_o rises. Results appear for one cycle on done_o; the receiver cannot stall.
// Reset clears all valid bits and loads timeout_q with 300000 at once.
`timescale 1ns / 1ps

module neighbor_table_engine #(
  parameter int unsigned ENTRIES = nte_pkg::EntriesDef,
  parameter int unsigned ID_BITS = nte_pkg::IdBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         op_i,
  input  logic [nte_pkg::KeyW-1:0]           node_id_i,
  input  logic signed [nte_pkg::RssiW-1:0]   rssi_i,
  input  logic [nte_pkg::TimeW-1:0]          now_ms_i,
  input  logic [nte_pkg::SlotW-1:0]          slot_index_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nte_pkg::TimeW-1:0]          cfg_data_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [nte_pkg::SlotW-1:0]          slot_used_o,
  output logic [nte_pkg::CountW-1:0]         active_count_o,
  output logic [nte_pkg::KeyW-1:0]           entry_id_o,
  output logic signed [nte_pkg::RssiW-1:0]   entry_rssi_o,
  output logic [nte_pkg::TimeW-1:0]          entry_last_heard_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_GETW = 4'b1000
  } state_e;

  state_e state_q, state_d;

  nte_pkg::op_e              op_q;
  logic [ID_BITS-1:0]        key_q;
  logic [nte_pkg::RssiW-1:0] rssi_q;
  logic [nte_pkg::TimeW-1:0] now_q;
  logic [nte_pkg::SlotW-1:0] slot_q;
  logic                      slot_ok_q;
  logic [nte_pkg::TimeW-1:0] timeout_q;

  logic [CntW-1:0]           idx_q, idx_d;
  logic                      pend_q, pend_d;
  logic [IdxW-1:0]           pend_idx_q, pend_idx_d;
  logic                      hit_q, hit_d;
  logic [IdxW-1:0]           hit_idx_q, hit_idx_d;
  logic [nte_pkg::RssiW-1:0] hit_str_q, hit_str_d;
  logic                      free_q, free_d;
  logic [IdxW-1:0]           free_idx_q, free_idx_d;
  logic [ENTRIES-1:0]        valid_q, valid_d;
  logic [CntW-1:0]           count_q, count_d;

  logic                       done_q, done_d;
  nte_pkg::status_e           status_q, status_d;
  logic [nte_pkg::SlotW-1:0]  slot_used_q, slot_used_d;
  logic [nte_pkg::CountW-1:0] cnt_out_q, cnt_out_d;
  logic [nte_pkg::KeyW-1:0]   id_q, id_d;
  logic [nte_pkg::RssiW-1:0]  str_q, str_d;
  logic [nte_pkg::TimeW-1:0]  last_q, last_d;

  logic                      mem_we;
  logic [IdxW-1:0]           mem_waddr;
  logic [nte_pkg::RssiW-1:0] mem_wstr;
  logic [IdxW-1:0]           mem_raddr;
  logic [ID_BITS-1:0]        rkey;
  logic [nte_pkg::RssiW-1:0] rstr;
  logic [nte_pkg::TimeW-1:0] rtime;

  logic                      accept;
  logic                      issue;
  logic                      match;
  logic [nte_pkg::TimeW-1:0] age;
  logic [nte_pkg::RssiW-1:0] new_str;
  logic signed [10:0]        smooth_sum;
  logic [IdxW-1:0]           slot_idx;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign issue       = (idx_q < CntW'(ENTRIES));
  assign slot_idx    = IdxW'(slot_q);

  // Shared compare unit: key match while heard scans, age test while prune scans
  assign age   = now_q - rtime;
  assign match = (op_q == nte_pkg::OP_HEARD) ? (rkey == key_q) : (age > timeout_q);

  // (4*old + new) / 5, truncated toward zero
  assign smooth_sum = $signed({hit_str_q[7], hit_str_q, 2'b00})
                    + $signed({{3{rssi_q[7]}}, rssi_q});
  assign new_str    = nte_pkg::div5_trunc(smooth_sum);

  nte_store #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wkey_i  (key_q),
    .wstr_i  (mem_wstr),
    .wtime_i (now_q),
    .raddr_i (mem_raddr),
    .rkey_o  (rkey),
    .rstr_o  (rstr),
    .rtime_o (rtime)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_str_d   = hit_str_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    valid_d     = valid_q;
    count_d     = count_q;
    done_d      = 1'b0;
    status_d    = status_q;
    slot_used_d = slot_used_q;
    cnt_out_d   = cnt_out_q;
    id_d        = id_q;
    str_d       = str_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_waddr   = hit_idx_q;
    mem_wstr    = rssi_q;
    mem_raddr   = idx_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        mem_raddr = IdxW'(slot_index_i);
        if (start_i) begin
          case (nte_pkg::op_e'(op_i))
            nte_pkg::OP_HEARD, nte_pkg::OP_PRUNE: begin
              state_d = S_SCAN;
              idx_d   = '0;
              hit_d   = 1'b0;
              free_d  = 1'b0;
            end
            nte_pkg::OP_GET: begin
              state_d = S_GETW;
            end
            nte_pkg::OP_COUNT: begin
              done_d      = 1'b1;
              status_d    = nte_pkg::STAT_OK;
              slot_used_d = '0;
              cnt_out_d   = nte_pkg::CountW'(count_q);
              id_d        = '0;
              str_d       = '0;
              last_d      = '0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read one slot per cycle, judge the slot read in the cycle before
        if (issue) begin
          idx_d      = idx_q + CntW'(1);
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IdxW-1:0];
        end
        if (pend_q) begin
          if (op_q == nte_pkg::OP_HEARD) begin
            if (valid_q[pend_idx_q] && match && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = pend_idx_q;
              hit_str_d = rstr;
            end
            if (!valid_q[pend_idx_q] && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = pend_idx_q;
            end
          end else if (valid_q[pend_idx_q] && match) begin
            valid_d[pend_idx_q] = 1'b0;
            count_d             = count_q - CntW'(1);
          end
        end
        if (!issue) begin
          state_d = S_UPD;
        end
      end

      S_UPD: begin
        state_d     = S_IDLE;
        done_d      = 1'b1;
        status_d    = nte_pkg::STAT_OK;
        slot_used_d = '0;
        cnt_out_d   = nte_pkg::CountW'(count_q);
        id_d        = '0;
        str_d       = '0;
        last_d      = '0;
        if (op_q == nte_pkg::OP_HEARD) begin
          if (hit_q) begin
            mem_we      = 1'b1;
            mem_waddr   = hit_idx_q;
            mem_wstr    = new_str;
            slot_used_d = nte_pkg::SlotW'(hit_idx_q);
            id_d        = nte_pkg::KeyW'(key_q);
            str_d       = new_str;
            last_d      = now_q;
          end else if (free_q) begin
            mem_we              = 1'b1;
            mem_waddr           = free_idx_q;
            mem_wstr            = rssi_q;
            valid_d[free_idx_q] = 1'b1;
            count_d             = count_q + CntW'(1);
            status_d            = nte_pkg::STAT_NEW;
            slot_used_d         = nte_pkg::SlotW'(free_idx_q);
            cnt_out_d           = nte_pkg::CountW'(count_q + CntW'(1));
            id_d                = nte_pkg::KeyW'(key_q);
            str_d               = rssi_q;
            last_d              = now_q;
          end else begin
            status_d = nte_pkg::STAT_FULL;
          end
        end
      end

      S_GETW: begin
        state_d     = S_IDLE;
        done_d      = 1'b1;
        slot_used_d = slot_q;
        cnt_out_d   = nte_pkg::CountW'(count_q);
        if (slot_ok_q && valid_q[slot_idx]) begin
          status_d = nte_pkg::STAT_OK;
          id_d     = nte_pkg::KeyW'(rkey);
          str_d    = rstr;
          last_d   = rtime;
        end else begin
          status_d = nte_pkg::STAT_INACTIVE;
          id_d     = '0;
          str_d    = '0;
          last_d   = '0;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      valid_q   <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      timeout_q <= nte_pkg::TimeoutRst;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      valid_q <= valid_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= nte_pkg::op_e'(op_i);
      key_q     <= node_id_i[ID_BITS-1:0];
      rssi_q    <= rssi_i;
      now_q     <= now_ms_i;
      slot_q    <= slot_index_i;
      slot_ok_q <= (32'(slot_index_i) < 32'(ENTRIES));
    end
    pend_idx_q  <= pend_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_str_q   <= hit_str_d;
    free_idx_q  <= free_idx_d;
    status_q    <= status_d;
    slot_used_q <= slot_used_d;
    cnt_out_q   <= cnt_out_d;
    id_q        <= id_d;
    str_q       <= str_d;
    last_q      <= last_d;
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign slot_used_o        = slot_used_q;
  assign active_count_o     = cnt_out_q;
  assign entry_id_o         = id_q;
  assign entry_rssi_o       = str_q;
  assign entry_last_heard_o = last_q;

  a_count_tracks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_q))
    else $error("active count out of step with valid bits");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_UPD || state_q == S_GETW
                     || (state_q == S_IDLE && start_i && op_i == nte_pkg::OP_COUNT)))
    else $error("result strobe without a finishing step");

  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && op_q == nte_pkg::OP_HEARD && hit_q) |-> valid_q[hit_idx_q])
    else $error("update targets an invalid slot");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == nte_pkg::STAT_FULL) |-> (32'(count_q) == 32'(ENTRIES)))
    else $error("table full reported with a free slot");

  a_scan_ends_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !issue) |=> (state_q == S_UPD))
    else $error("scan did not hand over to update");

endmodule

// ===== rtl/core/nte_store.sv =====
// Neighbor table entry store: key, strength and last-heard time per slot.
// One write port, one read port with registered read data. Uses nte_pkg.
`timescale 1ns / 1ps

module nte_store #(
  parameter int unsigned ENTRIES = nte_pkg::EntriesDef,
  parameter int unsigned ID_BITS = nte_pkg::IdBitsDef,
  localparam int unsigned IdxW   = $clog2(ENTRIES)
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [IdxW-1:0]                 waddr_i,
  input  logic [ID_BITS-1:0]              wkey_i,
  input  logic [nte_pkg::RssiW-1:0]       wstr_i,
  input  logic [nte_pkg::TimeW-1:0]       wtime_i,
  input  logic [IdxW-1:0]                 raddr_i,
  output logic [ID_BITS-1:0]              rkey_o,
  output logic [nte_pkg::RssiW-1:0]       rstr_o,
  output logic [nte_pkg::TimeW-1:0]       rtime_o
);

  logic [ID_BITS-1:0]        key_mem  [ENTRIES];
  logic [nte_pkg::RssiW-1:0] str_mem  [ENTRIES];
  logic [nte_pkg::TimeW-1:0] time_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i]  <= wkey_i;
      str_mem[waddr_i]  <= wstr_i;
      time_mem[waddr_i] <= wtime_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_o  <= key_mem[raddr_i];
    rstr_o  <= str_mem[raddr_i];
    rtime_o <= time_mem[raddr_i];
  end

endmodule
